@@ hdl/pfd_pkg.sv @@
// Shared types and constants for the Playfair digraph decryption block.
package pfd_pkg;

	localparam int SQ_DIM     = 5;
	localparam int CHAR_W     = 8;
	localparam int ROW_W      = SQ_DIM * CHAR_W;
	localparam int IDX_W      = $clog2(SQ_DIM);
	localparam int CFG_IDX_W  = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

	typedef logic [SQ_DIM-1:0][ROW_W-1:0] key_sq_t;

	typedef struct packed {
		logic [CHAR_W-1:0] first_char;
		logic [CHAR_W-1:0] second_char;
	} in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] plain_first;
		logic [CHAR_W-1:0] plain_second;
		logic              not_found;
	} out_t;

	// Located positions of both letters of one digraph.
	typedef struct packed {
		logic [IDX_W-1:0] row_a;
		logic [IDX_W-1:0] col_a;
		logic [IDX_W-1:0] row_b;
		logic [IDX_W-1:0] col_b;
		logic             found_a;
		logic             found_b;
	} cls_t;

endpackage

@@ hdl/pfd_front.sv @@
// Front end: folds both bytes to upper case and locates them in the key square.
module pfd_front (
	input  pfd_pkg::in_t    in_data,
	input  pfd_pkg::key_sq_t key,
	output pfd_pkg::cls_t   cls
);

	function automatic logic [pfd_pkg::CHAR_W-1:0] fold_upper(
		input logic [pfd_pkg::CHAR_W-1:0] c);
		if (c >= pfd_pkg::ASCII_LOWER_A && c <= pfd_pkg::ASCII_LOWER_Z) begin
			return c - pfd_pkg::CASE_OFFSET;
		end
		return c;
	endfunction

	// Scans in row-major order so that a later match overrides an earlier one.
	function automatic logic [2*pfd_pkg::IDX_W:0] locate(
		input logic [pfd_pkg::CHAR_W-1:0] c,
		input pfd_pkg::key_sq_t sq);
		logic [pfd_pkg::IDX_W-1:0] row;
		logic [pfd_pkg::IDX_W-1:0] col;
		logic                      hit;
		row = '0;
		col = '0;
		hit = 1'b0;
		for (int r = 0; r < pfd_pkg::SQ_DIM; r++) begin
			for (int k = 0; k < pfd_pkg::SQ_DIM; k++) begin
				if (sq[r][k*pfd_pkg::CHAR_W +: pfd_pkg::CHAR_W] == c) begin
					row = pfd_pkg::IDX_W'(r);
					col = pfd_pkg::IDX_W'(k);
					hit = 1'b1;
				end
			end
		end
		return {row, col, hit};
	endfunction

	logic [2*pfd_pkg::IDX_W:0] loc_a;
	logic [2*pfd_pkg::IDX_W:0] loc_b;

	assign loc_a = locate(fold_upper(in_data.first_char), key);
	assign loc_b = locate(fold_upper(in_data.second_char), key);

	always_comb begin
		{cls.row_a, cls.col_a, cls.found_a} = loc_a;
		{cls.row_b, cls.col_b, cls.found_b} = loc_b;
	end

endmodule

@@ hdl/pfd_queue.sv @@
// Small queue of located digraphs between the front end and the back end.
module pfd_queue #(
	parameter int Depth = pfd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pfd_pkg::cls_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output pfd_pkg::cls_t head_data
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	pfd_pkg::cls_t   mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/pfd_back.sv @@
// Back end: applies the Playfair decryption rules and holds the result register.
module pfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pfd_pkg::key_sq_t key,
	input  logic             head_valid,
	input  pfd_pkg::cls_t    head_data,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output pfd_pkg::out_t    out_data
);

	function automatic logic [pfd_pkg::IDX_W-1:0] prev_idx(
		input logic [pfd_pkg::IDX_W-1:0] x);
		return (x == '0) ? pfd_pkg::IDX_W'(pfd_pkg::SQ_DIM - 1) : x - 1'b1;
	endfunction

	function automatic logic [pfd_pkg::CHAR_W-1:0] sq_byte(
		input pfd_pkg::key_sq_t sq,
		input logic [pfd_pkg::IDX_W-1:0] r,
		input logic [pfd_pkg::IDX_W-1:0] c);
		return sq[r][c*pfd_pkg::CHAR_W +: pfd_pkg::CHAR_W];
	endfunction

	logic          out_valid_q;
	pfd_pkg::out_t out_data_q;
	pfd_pkg::out_t result;

	always_comb begin
		result = '0;
		if (!head_data.found_a || !head_data.found_b) begin
			result.not_found = 1'b1;
		end else if (head_data.row_a == head_data.row_b) begin
			result.plain_first  = sq_byte(key, head_data.row_a, prev_idx(head_data.col_a));
			result.plain_second = sq_byte(key, head_data.row_b, prev_idx(head_data.col_b));
		end else if (head_data.col_a == head_data.col_b) begin
			result.plain_first  = sq_byte(key, prev_idx(head_data.row_a), head_data.col_a);
			result.plain_second = sq_byte(key, prev_idx(head_data.row_b), head_data.col_b);
		end else begin
			result.plain_first  = sq_byte(key, head_data.row_a, head_data.col_b);
			result.plain_second = sq_byte(key, head_data.row_b, head_data.col_a);
		end
	end

	// A queued head loads the result register if empty or its output is taken.
	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ hdl/playfair_digraph_decrypt.sv @@
// Top level of the Playfair digraph decryption block.
// The block takes one ciphertext digraph per cycle while ready and returns its plaintext
// digraph; the 5x5 square search runs as 50 parallel byte compares in the front end, a
// queue of QueueDepth located digraphs decouples it from the back end, whose row/column
// selection feeds a single result register. Input ready drops only when the queue is full,
// which happens only while out_valid is high. Key rows must be written through the
// configuration port only while no transaction is in flight; the block does not check it.
module playfair_digraph_decrypt #(
	parameter int QueueDepth = pfd_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  pfd_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output pfd_pkg::out_t                   out_data,
	input  logic                            cfg_we,
	input  logic [pfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfd_pkg::ROW_W-1:0]       cfg_wdata
);

	pfd_pkg::key_sq_t key_q;
	pfd_pkg::cls_t    front_cls;
	pfd_pkg::cls_t    head_data;
	logic             queue_full;
	logic             head_valid;
	logic             pop;
	logic             push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we && cfg_index < pfd_pkg::CFG_IDX_W'(pfd_pkg::SQ_DIM)) begin
			key_q[cfg_index] <= cfg_wdata;
		end
	end

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	pfd_front u_front (
		.in_data (in_data),
		.key     (key_q),
		.cls     (front_cls)
	);

	pfd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (front_cls),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	pfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.key        (key_q),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

@@ hdl/pfd_checker.sv @@
// Port-level checks for the Playfair digraph decryption block, bound to the top level.
module pfd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input pfd_pkg::out_t                 out_data
);

	// A stalled result must hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// A missing letter gives zero plaintext.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.not_found |->
			out_data.plain_first == '0 && out_data.plain_second == '0)
		else $error("not_found result carries nonzero plaintext");

	// A fresh result follows an input transaction through the queue and the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a matching input transaction");

	// The input side backs up only while out_valid is high.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled while the result register is empty");

endmodule

bind playfair_digraph_decrypt pfd_checker u_pfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

@@ bench/playfair_digraph_decrypt_tb.sv @@
// Self-checking testbench for the Playfair digraph decryption block.
module playfair_digraph_decrypt_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 8;
	localparam int REPORT_LIMIT = 10;

	typedef logic [pfd_pkg::CHAR_W-1:0] char_t;

	typedef enum logic [pfd_pkg::CFG_IDX_W-1:0] {
		KEY_ROW_0 = 3'd0,
		KEY_ROW_1 = 3'd1,
		KEY_ROW_2 = 3'd2,
		KEY_ROW_3 = 3'd3,
		KEY_ROW_4 = 3'd4
	} key_reg_e;

	typedef enum int {
		SQ_PERM,
		SQ_PERM_LOWER,
		SQ_REPEATS,
		SQ_NOISE
	} square_kind_e;

	// Holds the predicted plaintext of every outstanding digraph, oldest first.
	class plain_board;
		char_t         grid [pfd_pkg::SQ_DIM][pfd_pkg::SQ_DIM];
		pfd_pkg::out_t plain_due [$];
		int            errors;

		function new();
			errors = 0;
			for (int r = 0; r < pfd_pkg::SQ_DIM; r++) begin
				for (int k = 0; k < pfd_pkg::SQ_DIM; k++) begin
					grid[r][k] = '0;
				end
			end
		endfunction

		function void set_row(int r, logic [pfd_pkg::ROW_W-1:0] row);
			for (int k = 0; k < pfd_pkg::SQ_DIM; k++) begin
				grid[r][k] = row[pfd_pkg::CHAR_W*k +: pfd_pkg::CHAR_W];
			end
		endfunction

		function char_t upper(char_t c);
			if (c >= pfd_pkg::ASCII_LOWER_A && c <= pfd_pkg::ASCII_LOWER_Z) begin
				return c - pfd_pkg::CASE_OFFSET;
			end
			return c;
		endfunction

		// Later cells overwrite earlier ones, so a repeated byte resolves to its last cell.
		function bit find_cell(char_t c, output int row, output int col);
			bit hit;
			hit = 1'b0;
			row = 0;
			col = 0;
			for (int r = 0; r < pfd_pkg::SQ_DIM; r++) begin
				for (int k = 0; k < pfd_pkg::SQ_DIM; k++) begin
					if (grid[r][k] == c) begin
						row = r;
						col = k;
						hit = 1'b1;
					end
				end
			end
			return hit;
		endfunction

		function pfd_pkg::out_t decrypt_digraph(pfd_pkg::in_t d);
			pfd_pkg::out_t res;
			int            ra, ca, rb, cb;
			bit            fa, fb;
			fa = find_cell(upper(d.first_char), ra, ca);
			fb = find_cell(upper(d.second_char), rb, cb);
			res = '0;
			if (!fa || !fb) begin
				res.not_found = 1'b1;
			end else if (ra == rb) begin
				res.plain_first  = grid[ra][(ca + pfd_pkg::SQ_DIM - 1) % pfd_pkg::SQ_DIM];
				res.plain_second = grid[rb][(cb + pfd_pkg::SQ_DIM - 1) % pfd_pkg::SQ_DIM];
			end else if (ca == cb) begin
				res.plain_first  = grid[(ra + pfd_pkg::SQ_DIM - 1) % pfd_pkg::SQ_DIM][ca];
				res.plain_second = grid[(rb + pfd_pkg::SQ_DIM - 1) % pfd_pkg::SQ_DIM][cb];
			end else begin
				res.plain_first  = grid[ra][cb];
				res.plain_second = grid[rb][ca];
			end
			return res;
		endfunction

		function void note_input(pfd_pkg::in_t d);
			plain_due.push_back(decrypt_digraph(d));
		endfunction

		function void flag(string what, pfd_pkg::out_t want, pfd_pkg::out_t got);
			errors++;
			if (errors <= REPORT_LIMIT) begin
				$display("%0t: %s: expected %h %h nf=%b, got %h %h nf=%b", $time, what,
					want.plain_first, want.plain_second, want.not_found,
					got.plain_first, got.plain_second, got.not_found);
			end
		endfunction

		function void check_result(pfd_pkg::out_t got);
			pfd_pkg::out_t want;
			if (plain_due.size() == 0) begin
				flag("result with nothing outstanding", '0, got);
				return;
			end
			want = plain_due.pop_front();
			if (got.plain_first !== want.plain_first || got.plain_second !== want.plain_second
					|| got.not_found !== want.not_found) begin
				flag("plaintext mismatch", want, got);
			end
		endfunction

		function int pending();
			return plain_due.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	pfd_pkg::in_t                  in_data;
	logic                          out_valid;
	logic                          out_ready;
	pfd_pkg::out_t                 out_data;
	logic                          cfg_we;
	logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pfd_pkg::ROW_W-1:0]     cfg_wdata;

	plain_board board = new();
	int         burst_left = 0;
	bit         hold_req = 1'b0;
	int         cycle_count = 0;

	playfair_digraph_decrypt u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			board.note_input(in_data);
		end
		if (out_valid && out_ready) begin
			board.check_result(out_data);
		end
	end

	// The sender works in bursts; valid stays high across a burst and drops only for a gap.
	task automatic send_pair(input char_t a, input char_t b);
		int gap;
		in_valid <= 1'b1;
		in_data  <= '{first_char: a, second_char: b};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(0, 30);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic load_square(input pfd_pkg::key_sq_t sq);
		for (int r = 0; r < pfd_pkg::SQ_DIM; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= key_reg_e'(r);
			cfg_wdata <= sq[r];
			board.set_row(r, sq[r]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// The first wait lets the last accepted transaction reach the scoreboard.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic pfd_pkg::key_sq_t make_square(square_kind_e kind);
		pfd_pkg::key_sq_t sq;
		char_t            letters [26];
		char_t            tmp;
		int               j;
		for (int i = 0; i < 26; i++) begin
			letters[i] = char_t'("A" + i);
		end
		for (int i = 25; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = letters[i];
			letters[i] = letters[j];
			letters[j] = tmp;
		end
		for (int i = 0; i < pfd_pkg::SQ_DIM * pfd_pkg::SQ_DIM; i++) begin
			case (kind)
				SQ_PERM:       tmp = letters[i];
				// Lower-case cells can never match, since input bytes are folded up.
				SQ_PERM_LOWER: tmp = ($urandom_range(0, 7) == 0)
					? letters[i] | pfd_pkg::CASE_OFFSET : letters[i];
				SQ_REPEATS:    tmp = char_t'("A" + $urandom_range(0, 5));
				default:       tmp = char_t'($urandom_range(0, 255));
			endcase
			sq[i / pfd_pkg::SQ_DIM][pfd_pkg::CHAR_W*(i % pfd_pkg::SQ_DIM) +: pfd_pkg::CHAR_W]
				= tmp;
		end
		return sq;
	endfunction

	// Mostly bytes taken from the square, so that all three decryption rules get exercised.
	function automatic char_t pick_char(pfd_pkg::key_sq_t sq);
		char_t c;
		case ($urandom_range(0, 9))
			0, 1: c = char_t'($urandom_range(0, 255));
			2: c = char_t'("A" + $urandom_range(0, 25))
				| ($urandom_range(0, 1) ? pfd_pkg::CASE_OFFSET : 8'h00);
			default: begin
				c = sq[$urandom_range(0, pfd_pkg::SQ_DIM - 1)]
					[pfd_pkg::CHAR_W*$urandom_range(0, pfd_pkg::SQ_DIM - 1) +: pfd_pkg::CHAR_W];
				if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) begin
					c = c | pfd_pkg::CASE_OFFSET;
				end
			end
		endcase
		return c;
	endfunction

	task automatic run_random(input pfd_pkg::key_sq_t sq, input int count);
		for (int i = 0; i < count; i++) begin
			send_pair(pick_char(sq), pick_char(sq));
		end
	endtask

	// Receiver: changes its stall pattern every so often, and honors one long hold-off.
	initial begin : receiver
		int mode;
		int left;
		int k;
		mode = 0;
		left = 0;
		k = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 200);
				end
				left--;
				k++;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (k % 3 != 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** playfair_digraph_decrypt: FAILED **");
		$finish;
	end

	initial begin : stimulus
		pfd_pkg::key_sq_t sq;
		string            classic;
		classic = "PLAYFIREXMBCDGHKNOQSTUVWZ";
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= KEY_ROW_0;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Square still at its reset value: every cell is a zero byte.
		send_pair(8'h00, 8'h00);
		send_pair(8'h00, "A");
		send_pair(8'hFF, 8'h00);
		drain();

		for (int i = 0; i < pfd_pkg::SQ_DIM * pfd_pkg::SQ_DIM; i++) begin
			sq[i / pfd_pkg::SQ_DIM][pfd_pkg::CHAR_W*(i % pfd_pkg::SQ_DIM) +: pfd_pkg::CHAR_W]
				= classic[i];
		end
		load_square(sq);
		send_pair("P", "F");   // same row, wraps to the right end
		send_pair("L", "Y");
		send_pair("P", "T");   // same column, wraps to the bottom
		send_pair("X", "W");
		send_pair("L", "N");   // same column
		send_pair("Z", "P");
		send_pair("E", "E");   // same letter twice
		send_pair("J", "A");   // letter missing from the square
		send_pair("A", "J");
		send_pair("p", "f");   // lower case folds up
		send_pair("a", "z");
		send_pair("Z", "a");
		send_pair(8'h60, "A"); // just outside the lower-case range
		send_pair("A", 8'h7B);
		send_pair(8'h00, 8'hFF);
		send_pair(8'h40, 8'h5B);
		send_pair("m", "K");
		send_pair("g", "d");
		run_random(sq, 200);
		drain();

		for (int p = 0; p < 8; p++) begin
			sq = make_square(square_kind_e'(p % 4));
			load_square(sq);
			if (p == 2) begin
				hold_req = 1'b1;
			end
			run_random(sq, 170);
			drain();
		end

		sq = {pfd_pkg::SQ_DIM{{pfd_pkg::ROW_W{1'b1}}}};
		load_square(sq);
		send_pair(8'hFF, 8'hFF);
		send_pair(8'hFF, 8'hFE);
		run_random(sq, 50);
		drain();

		sq = '0;
		load_square(sq);
		run_random(sq, 20);
		drain();

		if (board.errors == 0 && board.pending() == 0) begin
			$display("** playfair_digraph_decrypt: PASSED **");
		end else begin
			$display("** playfair_digraph_decrypt: FAILED **");
		end
		$finish;
	end

endmodule

@@ playfair_digraph_decrypt.f @@
hdl/pfd_pkg.sv
hdl/pfd_front.sv
hdl/pfd_queue.sv
hdl/pfd_back.sv
hdl/playfair_digraph_decrypt.sv
hdl/pfd_checker.sv
bench/playfair_digraph_decrypt_tb.sv
